// ===== rtl/stack_machine_execute_unit_assert.svh =====
// Assertion macros for the checker file.
// No dependencies.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define SMEU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SMEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/smeu_pkg.sv =====
// Types and codes for the stack machine execute unit.
// No dependencies.
package smeu_pkg;

  typedef enum logic [4:0] {
    OP_PUSH     = 5'd0,
    OP_DUP      = 5'd1,
    OP_COPY     = 5'd2,
    OP_SWAP     = 5'd3,
    OP_POP      = 5'd4,
    OP_SLIDE    = 5'd5,
    OP_ADD      = 5'd6,
    OP_SUB      = 5'd7,
    OP_MUL      = 5'd8,
    OP_DIV      = 5'd9,
    OP_MOD      = 5'd10,
    OP_STORE    = 5'd11,
    OP_RETRIEVE = 5'd12,
    OP_PUTC     = 5'd13,
    OP_PUTI     = 5'd14,
    OP_READC    = 5'd15,
    OP_READI    = 5'd16
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_TOOFEW  = 3'd3,
    ST_RANGE   = 3'd4,
    ST_NOMATCH = 3'd5,
    ST_DIVZERO = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_RDB,
    S_GETB,
    S_EXE,
    S_DIV,
    S_WB,
    S_WB2,
    S_HRD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [4:0]         func;
    logic signed [31:0] param;
    logic signed [31:0] read_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               emit_valid;
    logic signed [31:0] emit_value;
    logic               emit_is_char;
    logic [6:0]         depth;
  } out_t;

  typedef struct packed {
    logic start;
    logic is_mod;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } div_rsp_t;

endpackage

// ===== rtl/smeu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/smeu_div.sv =====
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on smeu_pkg.
module smeu_div import smeu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output div_rsp_t    rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        qneg_r, qneg_nxt;
  logic        rneg_r, rneg_nxt;
  logic        mod_r, mod_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    mod_nxt  = mod_r;
    trial    = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[31] ? -dividend : dividend;
      dvs_nxt  = divisor[31] ? -divisor : divisor;
      qneg_nxt = dividend[31] ^ divisor[31];
      rneg_nxt = dividend[31];
      mod_nxt  = req.is_mod;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
      end
      quo_nxt = {quo_r[30:0], ~trial[32]};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
    mod_r  <= mod_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = mod_r ? (rneg_r ? -rem_r : rem_r) : (qneg_r ? -quo_r : quo_r);

endmodule

// ===== rtl/stack_machine_execute_unit.sv =====
// Stack machine execute unit: data stack and heap in RAM, one instruction per beat.
// Depends on smeu_pkg, smeu_ram and smeu_div.
//
// Each input beat runs one instruction and gives one result beat. A beat holds
// the unit from acceptance to the next acceptance: a check state, up to two
// reads of the single stack RAM read port, an execute state, a heap read for
// retrieve, then a write back, two for swap; then its result is loaded into
// the output register. Push, read, pop and beats that fail a stack check go
// from the check state to the output. Div and mod wait in the bit-serial divider.
// A held result stalls the next result in its final cycle until the output
// register frees. After reset a clearing pass over every heap word wipes the heap valid
// bits before the first beat is taken. A new beat may be taken while the
// previous result still waits in the output register.
module stack_machine_execute_unit import smeu_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int HEAP_WORDS  = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int HA_W = $clog2(HEAP_WORDS);

  state_t      state_r, state_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  op_t         op_r;
  logic [31:0] param_r, rv_r;
  logic [31:0] top_r, top_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] res_r, res_nxt;
  status_t     stat_r, stat_nxt;
  logic        ev_r, ev_nxt;
  logic        ec_r, ec_nxt;
  logic [31:0] eval_r, eval_nxt;
  logic [HA_W-1:0] clr_r, clr_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;

  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [31:0]   st_wdata, st_rdata;
  logic            hp_we, hp_re;
  logic [HA_W-1:0] hp_waddr, hp_raddr;
  logic [32:0]     hp_wdata, hp_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [SP_W-1:0] sp_m1, sp_m2, copy_idx;
  logic sp_full, sp_lt2, sp_zero, p_ok, key_ok, accept;

  assign sp_m1    = sp_r - SP_W'(1);
  assign sp_m2    = sp_r - SP_W'(2);
  assign copy_idx = sp_m1 - param_r[SP_W-1:0];
  assign sp_full  = sp_r >= SP_W'(STACK_DEPTH);
  assign sp_lt2   = sp_r < SP_W'(2);
  assign sp_zero  = sp_r == '0;
  assign p_ok     = !param_r[31] && (param_r < 32'(sp_r));
  assign key_ok   = !top_r[31] && (top_r < 32'(HEAP_WORDS));
  assign in_stall = state_r != S_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    top_nxt   = top_r;
    sec_nxt   = sec_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    ev_nxt    = ev_r;
    ec_nxt    = ec_r;
    eval_nxt  = eval_r;
    clr_nxt   = clr_r;
    st_we     = 1'b0;
    st_waddr  = sp_r[AW-1:0];
    st_wdata  = top_r;
    st_re     = 1'b0;
    st_raddr  = sp_m1[AW-1:0];
    hp_we     = 1'b0;
    hp_waddr  = top_r[HA_W-1:0];
    hp_wdata  = {1'b1, sec_r};
    hp_re     = 1'b0;
    hp_raddr  = top_r[HA_W-1:0];
    div_req   = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt   = out_r;

    unique case (state_r)
      S_CLEAR: begin
        hp_we    = 1'b1;
        hp_waddr = clr_r;
        hp_wdata = '0;
        clr_nxt  = clr_r + HA_W'(1);
        if (clr_r == HA_W'(HEAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          stat_nxt  = ST_OK;
          ev_nxt    = 1'b0;
          ec_nxt    = 1'b0;
          eval_nxt  = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = S_RDB;
        st_re     = 1'b1;
        unique case (op_r)
          OP_PUSH, OP_READC, OP_READI: begin
            st_re     = 1'b0;
            state_nxt = S_FIN;
            if (sp_full) begin
              stat_nxt = ST_FULL;
            end else begin
              st_we    = 1'b1;
              st_wdata = (op_r == OP_PUSH) ? param_r :
                         (op_r == OP_READC) ? {24'd0, rv_r[7:0]} : rv_r;
              sp_nxt   = sp_r + SP_W'(1);
            end
          end
          OP_DUP: begin
            priority if (sp_zero) begin
              stat_nxt = ST_TOOFEW;
            end else if (sp_full) begin
              stat_nxt = ST_FULL;
            end else begin
              stat_nxt = ST_OK;
            end
          end
          OP_COPY: begin
            st_raddr = copy_idx[AW-1:0];
            priority if (sp_zero) begin
              stat_nxt = ST_EMPTY;
            end else if (sp_full) begin
              stat_nxt = ST_FULL;
            end else if (!p_ok) begin
              stat_nxt = ST_RANGE;
            end else begin
              stat_nxt = ST_OK;
            end
          end
          OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_STORE: begin
            if (sp_lt2) begin
              stat_nxt = ST_TOOFEW;
            end
          end
          OP_POP: begin
            st_re     = 1'b0;
            state_nxt = S_FIN;
            if (sp_zero) begin
              stat_nxt = ST_EMPTY;
            end else begin
              sp_nxt = sp_m1;
            end
          end
          OP_SLIDE: begin
            priority if (sp_zero) begin
              stat_nxt = ST_EMPTY;
            end else if (!p_ok) begin
              stat_nxt = ST_RANGE;
            end else begin
              stat_nxt = ST_OK;
            end
          end
          OP_RETRIEVE: begin
            if (sp_zero) begin
              stat_nxt = ST_EMPTY;
            end
          end
          OP_PUTC, OP_PUTI: begin
            if (sp_zero) begin
              stat_nxt = ST_TOOFEW;
            end
          end
          default: begin
            st_re     = 1'b0;
            state_nxt = S_FIN;
          end
        endcase
        if (stat_nxt != ST_OK) begin
          st_re     = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_RDB: begin
        top_nxt  = st_rdata;
        st_raddr = sp_m2[AW-1:0];
        if (op_r == OP_SWAP || op_r == OP_ADD || op_r == OP_SUB || op_r == OP_MUL ||
            op_r == OP_DIV || op_r == OP_MOD || op_r == OP_STORE) begin
          st_re     = 1'b1;
          state_nxt = S_GETB;
        end else begin
          state_nxt = S_EXE;
        end
      end
      S_GETB: begin
        sec_nxt   = st_rdata;
        state_nxt = S_EXE;
      end
      S_EXE: begin
        state_nxt = S_FIN;
        unique case (op_r)
          OP_DUP, OP_COPY: begin
            st_we  = 1'b1;
            sp_nxt = sp_r + SP_W'(1);
          end
          OP_SWAP: begin
            st_we     = 1'b1;
            st_waddr  = sp_m1[AW-1:0];
            st_wdata  = sec_r;
            state_nxt = S_WB2;
          end
          OP_SLIDE: begin
            st_we    = 1'b1;
            st_waddr = copy_idx[AW-1:0];
            sp_nxt   = sp_r - param_r[SP_W-1:0];
          end
          OP_ADD: begin
            res_nxt   = sec_r + top_r;
            state_nxt = S_WB;
          end
          OP_SUB: begin
            res_nxt   = sec_r - top_r;
            state_nxt = S_WB;
          end
          OP_MUL: begin
            res_nxt   = sec_r * top_r;
            state_nxt = S_WB;
          end
          OP_DIV, OP_MOD: begin
            if (top_r == '0) begin
              stat_nxt = ST_DIVZERO;
            end else begin
              div_req.start  = 1'b1;
              div_req.is_mod = op_r == OP_MOD;
              state_nxt      = S_DIV;
            end
          end
          OP_STORE: begin
            if (!key_ok) begin
              stat_nxt = ST_RANGE;
            end else begin
              hp_we  = 1'b1;
              sp_nxt = sp_m2;
            end
          end
          OP_RETRIEVE: begin
            if (!key_ok) begin
              stat_nxt = ST_RANGE;
            end else begin
              hp_re     = 1'b1;
              state_nxt = S_HRD;
            end
          end
          OP_PUTC, OP_PUTI: begin
            sp_nxt   = sp_m1;
            ev_nxt   = 1'b1;
            ec_nxt   = op_r == OP_PUTC;
            eval_nxt = (op_r == OP_PUTC) ? {24'd0, top_r[7:0]} : top_r;
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.value;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        st_we     = 1'b1;
        st_waddr  = sp_m2[AW-1:0];
        st_wdata  = res_r;
        sp_nxt    = sp_m1;
        state_nxt = S_FIN;
      end
      S_WB2: begin
        st_we     = 1'b1;
        st_waddr  = sp_m2[AW-1:0];
        state_nxt = S_FIN;
      end
      S_HRD: begin
        if (!hp_rdata[32]) begin
          stat_nxt = ST_NOMATCH;
        end else begin
          st_we    = 1'b1;
          st_waddr = sp_m1[AW-1:0];
          st_wdata = hp_rdata[31:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = stat_r;
          out_nxt.emit_valid   = ev_r;
          out_nxt.emit_value   = eval_r;
          out_nxt.emit_is_char = ec_r;
          out_nxt.depth        = 7'(sp_r);
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sp_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      op_r    <= op_t'(in_data.func);
      param_r <= in_data.param;
      rv_r    <= in_data.read_value;
    end
    top_r  <= top_nxt;
    sec_r  <= sec_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
    ev_r   <= ev_nxt;
    ec_r   <= ec_nxt;
    eval_r <= eval_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  smeu_ram #(.WIDTH(33), .DEPTH(HEAP_WORDS)) u_heap (
    .clk     (clk),
    .wr_en   (hp_we),
    .wr_addr (hp_waddr),
    .wr_data (hp_wdata),
    .rd_en   (hp_re),
    .rd_addr (hp_raddr),
    .rd_data (hp_rdata)
  );

  smeu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (sec_r),
    .divisor  (top_r),
    .rsp      (div_rsp)
  );

endmodule

// ===== rtl/smeu_checker.sv =====
// Port-level checks for the stack machine execute unit, bound to the top level.
// Depends on smeu_pkg and stack_machine_execute_unit_assert.svh.
`include "stack_machine_execute_unit_assert.svh"

module smeu_checker import smeu_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `SMEU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, $stable(out_data))
  `SMEU_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)
  `SMEU_ASSERT_NOW(a_emit_ok, clk, rst_n, out_valid && out_data.emit_valid, out_data.status == ST_OK)
  `SMEU_ASSERT_NOW(a_char_byte, clk, rst_n, out_valid && out_data.emit_is_char, out_data.emit_valid && out_data.emit_value[31:8] == 24'd0)

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/stack_machine_execute_unit_test.sv =====
// Testbench for stack_machine_execute_unit: random and directed instruction beats,
// checked against an in-bench model of the stack and heap. Depends on smeu_pkg.
`timescale 1ns / 100ps

module stack_machine_execute_unit_test;
  import smeu_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int HEAP_WORDS  = 256;
  localparam int IDLE_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  stack_machine_execute_unit #(
    .STACK_DEPTH(STACK_DEPTH),
    .HEAP_WORDS(HEAP_WORDS)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] mdl_stack [STACK_DEPTH];
  int          mdl_sp;
  logic [31:0] mdl_heap [HEAP_WORDS];
  logic        mdl_heap_ok [HEAP_WORDS];
  out_t        expected_q [$];
  int          n_errors;
  int          idle_cycles;
  bit          quiet;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic out_t execute(input in_t it);
    out_t r;
    status_t st;
    logic [31:0] a, b, v;
    logic signed [31:0] p;
    int sp;
    int ki;
    r = '0;
    st = ST_OK;
    sp = mdl_sp;
    p = it.param;
    case (it.func)
      OP_PUSH, OP_DUP, OP_COPY, OP_READC, OP_READI: begin
        if (it.func == OP_DUP && sp < 1) st = ST_TOOFEW;
        else if (it.func == OP_COPY && sp == 0) st = ST_EMPTY;
        else if (sp >= STACK_DEPTH) st = ST_FULL;
        else if (it.func == OP_COPY && (p < 0 || p >= sp)) st = ST_RANGE;
        else begin
          case (it.func)
            OP_PUSH:  v = it.param;
            OP_DUP:   v = mdl_stack[sp-1];
            OP_COPY:  v = mdl_stack[sp-1-int'(p)];
            OP_READC: v = {24'd0, it.read_value[7:0]};
            default:  v = it.read_value;
          endcase
          mdl_stack[sp] = v;
          sp++;
        end
      end
      OP_SWAP: begin
        if (sp < 2) st = ST_TOOFEW;
        else begin
          a = mdl_stack[sp-1];
          mdl_stack[sp-1] = mdl_stack[sp-2];
          mdl_stack[sp-2] = a;
        end
      end
      OP_POP: begin
        if (sp == 0) st = ST_EMPTY;
        else sp--;
      end
      OP_SLIDE: begin
        if (sp == 0) st = ST_EMPTY;
        else if (p < 0 || p >= sp) st = ST_RANGE;
        else begin
          mdl_stack[sp-1-int'(p)] = mdl_stack[sp-1];
          sp -= int'(p);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (sp < 2) st = ST_TOOFEW;
        else begin
          b = mdl_stack[sp-1];
          a = mdl_stack[sp-2];
          if ((it.func == OP_DIV || it.func == OP_MOD) && b == 0) st = ST_DIVZERO;
          else begin
            case (it.func)
              OP_ADD: v = a + b;
              OP_SUB: v = a - b;
              OP_MUL: v = a * b;
              OP_DIV: v = (a == 32'h8000_0000 && b == '1) ? a :
                          32'($signed(a) / $signed(b));
              default: v = (a == 32'h8000_0000 && b == '1) ? '0 :
                           32'($signed(a) % $signed(b));
            endcase
            mdl_stack[sp-2] = v;
            sp--;
          end
        end
      end
      OP_STORE: begin
        if (sp < 2) st = ST_TOOFEW;
        else if ($signed(mdl_stack[sp-1]) < 0 || $signed(mdl_stack[sp-1]) >= HEAP_WORDS)
          st = ST_RANGE;
        else begin
          ki = int'(mdl_stack[sp-1]);
          mdl_heap[ki] = mdl_stack[sp-2];
          mdl_heap_ok[ki] = 1'b1;
          sp -= 2;
        end
      end
      OP_RETRIEVE: begin
        if (sp == 0) st = ST_EMPTY;
        else if ($signed(mdl_stack[sp-1]) < 0 || $signed(mdl_stack[sp-1]) >= HEAP_WORDS)
          st = ST_RANGE;
        else if (!mdl_heap_ok[int'(mdl_stack[sp-1])]) st = ST_NOMATCH;
        else mdl_stack[sp-1] = mdl_heap[int'(mdl_stack[sp-1])];
      end
      OP_PUTC, OP_PUTI: begin
        if (sp == 0) st = ST_TOOFEW;
        else begin
          a = mdl_stack[sp-1];
          sp--;
          r.emit_valid = 1'b1;
          r.emit_is_char = (it.func == OP_PUTC);
          r.emit_value = (it.func == OP_PUTC) ? {24'd0, a[7:0]} : a;
        end
      end
      default: ;
    endcase
    if (st == ST_OK) mdl_sp = sp;
    else begin
      r.emit_valid = 1'b0;
      r.emit_value = '0;
      r.emit_is_char = 1'b0;
    end
    r.status = st;
    r.depth = 7'(mdl_sp);
    return r;
  endfunction

  task automatic send_beat(input logic [4:0] func, input logic [31:0] param,
                           input logic [31:0] rdv);
    in_t it;
    it.func = func;
    it.param = param;
    it.read_value = rdv;
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(execute(it));
    @(negedge clk);
  endtask

  task automatic send_op(input op_t op, input logic [31:0] param = '0);
    send_beat(op, param, $urandom);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data.status, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.emit_valid !== want.emit_valid)
          report_mismatch("emit_valid", out_data.emit_valid, want.emit_valid);
        if (out_data.emit_value !== want.emit_value)
          report_mismatch("emit_value", out_data.emit_value, want.emit_value);
        if (out_data.emit_is_char !== want.emit_is_char)
          report_mismatch("emit_is_char", out_data.emit_is_char, want.emit_is_char);
        if (out_data.depth !== want.depth)
          report_mismatch("depth", out_data.depth, want.depth);
      end
    end
  end

  always @(negedge clk) out_stall <= !quiet && ($urandom_range(99) < 13);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stack_machine_execute_unit test failed");
      $finish;
    end
  end

  task automatic test_errors_on_empty();
    send_op(OP_DUP); send_op(OP_COPY); send_op(OP_SWAP); send_op(OP_POP);
    send_op(OP_SLIDE); send_op(OP_ADD); send_op(OP_STORE); send_op(OP_RETRIEVE);
    send_op(OP_PUTC); send_op(OP_PUTI);
    send_beat(5'd17, '0, '0); send_beat(5'd31, '1, '1);
  endtask

  task automatic test_arith_corners();
    send_op(OP_PUSH, 32'h8000_0000); send_op(OP_PUSH, 32'hffff_ffff); send_op(OP_DIV);
    send_op(OP_PUSH, 32'hffff_ffff); send_op(OP_MOD);
    send_op(OP_PUSH, 32'h7fff_ffff); send_op(OP_PUSH, 0); send_op(OP_DIV);
    send_op(OP_COPY, 32'hffff_ffff); send_op(OP_SLIDE, 5); send_op(OP_PUSH, 300);
    send_op(OP_RETRIEVE); send_op(OP_PUSH, 7); send_op(OP_RETRIEVE);
    send_op(OP_PUSH, 7); send_op(OP_STORE); send_op(OP_PUSH, 7); send_op(OP_RETRIEVE);
    send_beat(OP_READC, '0, 32'h1234_56ff); send_op(OP_PUTC); send_op(OP_PUTI);
  endtask

  task automatic test_full_stack();
    repeat (STACK_DEPTH) send_beat(OP_READI, '0, $urandom);
    send_op(OP_PUSH, 1); send_op(OP_DUP); send_op(OP_COPY, 63); send_op(OP_SLIDE, 63);
  endtask

  task automatic test_random_programs(input int n);
    int k, pick;
    logic [31:0] prm;
    for (k = 0; k < n; k++) begin
      quiet = (k >= n / 3 && k < n / 2);
      pick = $urandom_range(99);
      prm = $urandom;
      if (pick < 80) begin
        case ($urandom_range(3))
          0: prm = $urandom_range(HEAP_WORDS - 1);
          1: prm = mdl_sp > 0 ? $urandom_range(mdl_sp - 1) : 0;
          2: prm = $urandom_range(4) - 2;
          default: ;
        endcase
        if (mdl_sp < 4) send_beat($urandom_range(2) == 0 ? OP_PUSH : OP_READI, prm, $urandom);
        else if (mdl_sp > 50) send_beat(5'(OP_ADD + $urandom_range(4)), prm, $urandom);
        else send_beat(5'($urandom_range(16)), prm, $urandom);
      end else begin
        send_beat(5'($urandom), prm, $urandom);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    n_errors = 0;
    quiet = 1'b0;
    mdl_sp = 0;
    for (int i = 0; i < HEAP_WORDS; i++) mdl_heap_ok[i] = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_errors_on_empty();
    test_arith_corners();
    test_full_stack();
    while (mdl_sp > 0) send_op(OP_POP);
    test_random_programs(1450);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("stack_machine_execute_unit test passed");
    end else begin
      $display("stack_machine_execute_unit test failed");
    end
    $finish;
  end

endmodule
